// File: sv/tla_pkg.sv
package tla_pkg;

    // Configuration register indexes
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_ACTION_COUNT    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SET_TILINGS     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TILES_PER_DIM   = 2'd2;

    // Input modes
    localparam logic MODE_TILING = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_SUMMARY = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // Highest valid memory tier
    localparam logic [7:0] TIER_LAST = 8'd2;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = 6;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 256;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } tla_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic commit;
    } tla_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic mul_zero;
        logic div_done;
    } tla_sts_t;

endpackage

// File: sv/tla_ctrl.sv
module tla_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tla_pkg::tla_sts_t sts,
    output tla_pkg::tla_cmd_t cmd
);
    import tla_pkg::*;

    tla_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.skip) begin
                    state_next = S_OUT;
                end else if (sts.mul_zero) begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until taken, raise it on commit
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_tready))
        else $error("result committed over a pending transaction");
`endif

endmodule

// File: sv/tla_dpath.sv
module tla_dpath #(
    parameter int MAX_DIMS    = 16,
    parameter int MAX_TILINGS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tla_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    input  logic [tla_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [tla_pkg::S_TUSER_W-1:0]  s_tuser,
    input  tla_pkg::tla_cmd_t              cmd,
    output tla_pkg::tla_sts_t              sts,
    output logic [tla_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [tla_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tla_pkg::*;

    localparam int PW = $clog2(MAX_TILINGS + 1);
    localparam logic [6:0]    MaxDimsV    = 7'(MAX_DIMS);
    localparam logic [PW-1:0] MaxTilingsV = PW'(MAX_TILINGS);

    // Configuration registers
    logic [15:0] action_count_reg, tilings_reg, tiles_dim_reg;

    // Layout state
    logic [1:0]    cur_tier_reg, cur_tier_next;
    logic [31:0]   run_start_reg, run_start_next;
    logic [31:0]   run_off_reg, run_off_next;
    logic [31:0]   edge_reg [3];
    logic [31:0]   edge_next [3];
    logic [PW-1:0] placed_reg, placed_next;
    logic [15:0]   work_reg, work_next;

    // Item registers
    logic        mode_reg;
    logic [4:0]  dims_reg;
    logic [1:0]  tcode_reg;
    logic        reject_reg;
    logic [31:0] tiles_reg;
    logic [5:0]  mul_left_reg;
    logic        first_reg;

    // Divider
    logic [31:0]       quot_reg;
    logic [15:0]       rem_reg;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [16:0]       trial;
    logic [16:0]       diff;

    // Output registers
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic        in_mode;
    logic [4:0]  in_dims;
    logic [7:0]  in_tcode;
    logic        in_reject;
    logic [31:0] product;
    logic [15:0] mul_op;

    assign in_mode  = s_tuser[0];
    assign in_dims  = s_tdata[4:0];
    assign in_tcode = s_tdata[12:5];

    // Reject check against the state as it stands at acceptance
    assign in_reject = (placed_reg >= MaxTilingsV) ||
                       ((in_dims != 5'd0) &&
                        (({2'b00, in_dims} > MaxDimsV) ||
                         (in_tcode > TIER_LAST) ||
                         (in_tcode < {6'd0, cur_tier_reg})));

    assign mul_op  = first_reg ? tilings_reg : tiles_dim_reg;
    assign product = tiles_reg * {16'd0, mul_op};

    assign trial = {rem_reg, quot_reg[31]};
    assign diff  = trial - {1'b0, tilings_reg};

    assign sts.skip     = (mode_reg == MODE_FINISH) || reject_reg;
    assign sts.mul_zero = (mul_left_reg == 6'd0);
    assign sts.div_done = (div_cnt_reg == DIV_CW'(DIV_STEPS));

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            action_count_reg <= 16'd1;
            tilings_reg      <= 16'd1;
            tiles_dim_reg    <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ACTION_COUNT:    action_count_reg <= cfg_wdata;
                CFG_SET_TILINGS:     tilings_reg      <= cfg_wdata;
                CFG_TILES_PER_DIM:   tiles_dim_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the item, then iterate the tile count product
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg     <= in_mode;
            dims_reg     <= in_dims;
            tcode_reg    <= in_tcode[1:0];
            reject_reg   <= in_reject;
            tiles_reg    <= {16'd0, action_count_reg};
            first_reg    <= 1'b1;
            mul_left_reg <= (in_dims == 5'd0 || in_mode == MODE_FINISH || in_reject)
                            ? 6'd0 : ({1'b0, in_dims} + 6'd1);
        end else if (cmd.mul_step) begin
            tiles_reg    <= product;
            first_reg    <= 1'b0;
            mul_left_reg <= mul_left_reg - 6'd1;
        end
    end

    // Restoring divide of the tile count by the tilings per set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_init) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quot_reg <= tiles_reg;
            rem_reg  <= 16'd0;
        end else if (cmd.div_step) begin
            if (!diff[16]) begin
                rem_reg  <= diff[15:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= trial[15:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end

    // Result and state update at commit
    always_comb begin
        logic [1:0]  new_tier;
        logic [31:0] base_off;
        logic [31:0] sum_start;
        logic [31:0] size_q;

        cur_tier_next  = cur_tier_reg;
        run_start_next = run_start_reg;
        run_off_next   = run_off_reg;
        placed_next    = placed_reg;
        work_next      = work_reg;
        for (int i = 0; i < 3; i++) begin
            edge_next[i] = edge_reg[i];
        end
        new_tier  = (dims_reg != 5'd0) ? tcode_reg : cur_tier_reg;
        base_off  = (new_tier != cur_tier_reg) ? 32'd0 : run_off_reg;
        sum_start = run_start_reg + tiles_reg;
        size_q    = (tilings_reg != 16'd0) ? quot_reg : 32'd0;
        m_tdata_next = '0;
        m_tuser_next = '0;

        if (mode_reg == MODE_FINISH) begin
            // Fill remaining edges, report totals, clear accumulators
            for (int i = 0; i < 3; i++) begin
                if (2'(i) >= cur_tier_reg) begin
                    edge_next[i] = run_start_reg;
                end
            end
            m_tuser_next = {1'b1, ST_SUMMARY};
            m_tdata_next[65:34]   = run_start_reg;
            m_tdata_next[232:226] = 7'(placed_reg);
            m_tdata_next[248:233] = work_reg;
            cur_tier_next  = 2'd0;
            run_start_next = 32'd0;
            run_off_next   = 32'd0;
            placed_next    = '0;
            work_next      = 16'd0;
        end else if (reject_reg) begin
            m_tuser_next = {1'b0, ST_REJECT};
            m_tdata_next[232:226] = 7'(placed_reg);
            m_tdata_next[248:233] = work_reg;
        end else begin
            // Advance tier edges, place the tiling
            for (int i = 0; i < 3; i++) begin
                if (2'(i) >= cur_tier_reg && 2'(i) < new_tier) begin
                    edge_next[i] = run_start_reg;
                end
                if (2'(i) == new_tier) begin
                    edge_next[i] = sum_start;
                end
            end
            cur_tier_next  = new_tier;
            run_start_next = sum_start;
            run_off_next   = base_off + tiles_reg;
            placed_next    = placed_reg + PW'(1);
            work_next      = work_reg + ((dims_reg != 5'd0) ? tilings_reg : 16'd1);
            m_tuser_next = {1'b0, ST_PLACED};
            m_tdata_next[1:0]     = (dims_reg != 5'd0) ? new_tier : 2'd0;
            m_tdata_next[33:2]    = (dims_reg != 5'd0) ? run_start_reg : 32'd0;
            m_tdata_next[65:34]   = sum_start;
            m_tdata_next[97:66]   = (dims_reg != 5'd0) ? base_off : 32'd0;
            m_tdata_next[129:98]  = size_q;
            m_tdata_next[232:226] = 7'(placed_reg);
            m_tdata_next[248:233] = work_next;
        end
        m_tdata_next[161:130] = edge_next[0];
        m_tdata_next[193:162] = edge_next[1];
        m_tdata_next[225:194] = edge_next[2];
    end

    // Layout state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_tier_reg  <= 2'd0;
            run_start_reg <= 32'd0;
            run_off_reg   <= 32'd0;
            placed_reg    <= '0;
            work_reg      <= 16'd0;
            for (int i = 0; i < 3; i++) begin
                edge_reg[i] <= 32'd0;
            end
        end else if (cmd.commit) begin
            cur_tier_reg  <= cur_tier_next;
            run_start_reg <= run_start_next;
            run_off_reg   <= run_off_next;
            placed_reg    <= placed_next;
            work_reg      <= work_next;
            for (int i = 0; i < 3; i++) begin
                edge_reg[i] <= edge_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.div_done && ($past(div_cnt_reg) == DIV_CW'(DIV_STEPS - 1)) &&
         (tilings_reg != 16'd0)) |->
        ((48'(quot_reg) * 48'(tilings_reg) + 48'(rem_reg)) == 48'(tiles_reg)) &&
        (rem_reg < tilings_reg))
        else $error("divider result inconsistent with dividend");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cnt_reg <= DIV_CW'(DIV_STEPS))
        else $error("divider step count overrun");
    a_placed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        placed_reg <= MaxTilingsV)
        else $error("placed count beyond table size");
`endif

endmodule

// File: sv/tiling_layout_allocator.sv
// Tiling layout allocator: places tile-coding tilings in a three-tier tile space.
// Steps from acceptance to m_tvalid for a placed tiling: dims + 1 serial 32x16 multiply steps,
// a divider start, 32 divider steps and a done check, then a commit once the output is free;
// a bias tiling skips the multiply steps, and finish and rejected items go straight to commit.
// One item in flight; s_tready returns in the cycle after the result is registered.
// Reset (aresetn, synchronous, active low) clears layout state, sets config registers to 1.
module tiling_layout_allocator #(
    parameter int MAX_DIMS    = 16,
    parameter int MAX_TILINGS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tla_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dims[4:0], tier_code[12:5], zero pad [15:13]
    input  logic [tla_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic [tla_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tier[1:0], tile_first[33:2], tile_past[65:34], tier_offset[97:66],
    // size_per_tiling[129:98], edge_tier_one[161:130], edge_tier_two[193:162],
    // edge_tier_three[225:194], tiling_number[232:226], work_total[248:233],
    // zero pad [255:249]
    output logic [tla_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0], done_res[2]
    output logic [tla_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tla_pkg::*;

    tla_cmd_t cmd;
    tla_sts_t sts;

    tla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tla_dpath #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_TILINGS (MAX_TILINGS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: dv/tiling_layout_allocator_checker.sv
`timescale 1ns / 1ps

module tiling_layout_allocator_checker #(
    parameter int MAX_DIMS    = 16,
    parameter int MAX_TILINGS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tla_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // dims[4:0], tier_code[12:5], zero pad [15:13]
    input  logic [tla_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic [tla_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // tier, start, end, offset, size, three tier ends, number, work, zero pad
    input  logic [tla_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0], done_res[2]
    input  logic [tla_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                             fail_count,
    output int                             pending
);
    import tla_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  tier;
        logic [31:0] tile_first;
        logic [31:0] tile_past;
        logic [31:0] tier_offset;
        logic [31:0] size_per_tiling;
        logic [31:0] bound_one;
        logic [31:0] bound_two;
        logic [31:0] bound_three;
        logic [6:0]  tiling_number;
        logic [15:0] work_total;
        logic        done_res;
    } layout_result_t;

    // Shadow copies of the configuration registers
    logic [15:0] action_cnt;
    logic [15:0] tiling_cnt;
    logic [15:0] dim_tiles;

    // Layout state as the block should hold it
    int unsigned    cur_tier;
    logic [31:0]    run_start;
    logic [31:0]    run_offset;
    logic [31:0]    tier_end [3];
    int unsigned    placed;
    logic [15:0]    work_cnt;

    layout_result_t expected_layout [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            flag_error($sformatf("%s expected 0x%0h got 0x%0h", what, want_v, got_v));
        end
    endtask

    // Place one descriptor or close the layout; return the result it should produce
    function automatic layout_result_t predict_layout(input logic mode,
                                                      input logic [4:0] dims,
                                                      input logic [7:0] tcode);
        layout_result_t res;
        logic [31:0]    tiles;
        res = '0;
        if (mode == MODE_FINISH) begin
            // fill every tier end not yet reached, then clear the accumulators
            while (cur_tier <= 2) begin
                tier_end[cur_tier] = run_start;
                cur_tier++;
            end
            res.status        = ST_SUMMARY;
            res.tile_past     = run_start;
            res.tiling_number = 7'(placed);
            res.work_total    = work_cnt;
            res.done_res      = 1'b1;
            cur_tier   = 0;
            run_start  = '0;
            run_offset = '0;
            placed     = 0;
            work_cnt   = '0;
        end else if (placed >= MAX_TILINGS ||
                     (dims != 0 && (dims > MAX_DIMS || tcode > TIER_LAST ||
                                    tcode < cur_tier))) begin
            res.status        = ST_REJECT;
            res.tiling_number = 7'(placed);
            res.work_total    = work_cnt;
        end else begin
            tiles = 32'(action_cnt);
            if (dims == 0) begin
                // bias tiling stays in the current tier
                work_cnt = work_cnt + 16'd1;
            end else begin
                tiles = tiles * 32'(tiling_cnt);
                for (int k = 0; k < dims; k++) begin
                    tiles = tiles * 32'(dim_tiles);
                end
                // close every tier passed over
                while (cur_tier < tcode) begin
                    run_offset         = '0;
                    tier_end[cur_tier] = run_start;
                    cur_tier++;
                end
                res.tier        = tcode[1:0];
                res.tile_first  = run_start;
                res.tier_offset = run_offset;
                work_cnt        = work_cnt + tiling_cnt;
            end
            run_start  = run_start + tiles;
            run_offset = run_offset + tiles;
            if (cur_tier <= 2) begin
                tier_end[cur_tier] = run_start;
            end
            res.status          = ST_PLACED;
            res.tile_past       = run_start;
            res.size_per_tiling = (tiling_cnt != 0) ? tiles / 32'(tiling_cnt) : '0;
            res.tiling_number   = 7'(placed);
            res.work_total      = work_cnt;
            placed++;
        end
        res.bound_one   = tier_end[0];
        res.bound_two   = tier_end[1];
        res.bound_three = tier_end[2];
        return res;
    endfunction

    // Track register writes, predict on input transactions, compare output transactions
    always @(posedge aclk) begin : watch
        layout_result_t got;
        layout_result_t want;
        if (!aresetn) begin
            action_cnt = 16'd1;
            tiling_cnt = 16'd1;
            dim_tiles  = 16'd1;
            cur_tier   = 0;
            run_start  = '0;
            run_offset = '0;
            tier_end   = '{default: '0};
            placed     = 0;
            work_cnt   = '0;
            expected_layout.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ACTION_COUNT:    action_cnt = cfg_wdata;
                    CFG_SET_TILINGS:     tiling_cnt = cfg_wdata;
                    CFG_TILES_PER_DIM:   dim_tiles  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.tier            = m_tdata[1:0];
                got.tile_first      = m_tdata[33:2];
                got.tile_past       = m_tdata[65:34];
                got.tier_offset     = m_tdata[97:66];
                got.size_per_tiling = m_tdata[129:98];
                got.bound_one       = m_tdata[161:130];
                got.bound_two       = m_tdata[193:162];
                got.bound_three     = m_tdata[225:194];
                got.tiling_number   = m_tdata[232:226];
                got.work_total      = m_tdata[248:233];
                got.status          = m_tuser[1:0];
                got.done_res        = m_tuser[2];
                if (expected_layout.size() == 0) begin
                    flag_error($sformatf("result with nothing pending, status %0d",
                                         got.status));
                end else begin
                    want = expected_layout.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("tier", 32'(want.tier), 32'(got.tier));
                    check_field("tile_first", want.tile_first, got.tile_first);
                    check_field("tile_past", want.tile_past, got.tile_past);
                    check_field("tier_offset", want.tier_offset, got.tier_offset);
                    check_field("size_per_tiling", want.size_per_tiling,
                                got.size_per_tiling);
                    check_field("edge_tier_one", want.bound_one, got.bound_one);
                    check_field("edge_tier_two", want.bound_two, got.bound_two);
                    check_field("edge_tier_three", want.bound_three, got.bound_three);
                    check_field("tiling_number", 32'(want.tiling_number),
                                32'(got.tiling_number));
                    check_field("work_total", 32'(want.work_total), 32'(got.work_total));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_layout.push_back(predict_layout(s_tuser[0], s_tdata[4:0],
                                                         s_tdata[12:5]));
            end
        end
        pending = expected_layout.size();
    end

endmodule

// File: dv/tiling_layout_allocator_tb.sv
`timescale 1ns / 1ps

module tiling_layout_allocator_tb;
    import tla_pkg::*;

    localparam int MAX_DIMS    = 16;
    localparam int MAX_TILINGS = 64;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_AW-1:0]     cfg_addr;
    logic [15:0]           cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // dims[4:0], tier_code[12:5], zero pad [15:13]
    logic [S_TDATA_W-1:0]  s_tdata;
    // mode[0]
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // tier, start, end, offset, size, three tier ends, number, work, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    // status[1:0], done_res[2]
    logic [M_TUSER_W-1:0]  m_tuser;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_stall_pct;

    tiling_layout_allocator #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_TILINGS (MAX_TILINGS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tiling_layout_allocator_checker #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_TILINGS (MAX_TILINGS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Present one item, with random idle cycles ahead of it, and hold until accepted
    task automatic send_item(input logic mode, input logic [4:0] dims,
                             input logic [7:0] tcode);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, tcode, dims};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_config(input logic [15:0] actions, input logic [15:0] tilings,
                              input logic [15:0] tiles);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_ACTION_COUNT;
        cfg_wdata <= actions;
        @(negedge aclk);
        cfg_addr  <= CFG_SET_TILINGS;
        cfg_wdata <= tilings;
        @(negedge aclk);
        cfg_addr  <= CFG_TILES_PER_DIM;
        cfg_wdata <= tiles;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Favor the extremes and small values, with full-range values mixed in
    function automatic logic [15:0] pick_reg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return 16'd1;
        end else if (r < 4) begin
            return 16'hFFFF;
        end else if (r < 7) begin
            return 16'($urandom_range(1, 8));
        end
        return 16'($urandom_range(1, 65535));
    endfunction

    // Mostly well-formed layouts with nondecreasing tiers, some noise and unfinished runs
    task automatic run_layouts(input int quota);
        int sent;
        int len;
        int lvl;
        sent = 0;
        lvl  = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 99) < 85) begin
                // long layouts run into a full table
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                  : $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(MODE_TILING, 5'($urandom_range(0, 31)), 8'($urandom));
                    end else if ($urandom_range(0, 6) == 0) begin
                        send_item(MODE_TILING, 5'd0, 8'($urandom));
                    end else begin
                        if (lvl < 2 && $urandom_range(0, 3) == 0) begin
                            lvl = $urandom_range(lvl + 1, 2);
                        end
                        send_item(MODE_TILING, 5'($urandom_range(1, MAX_DIMS)), 8'(lvl));
                    end
                    sent++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(MODE_FINISH, 5'($urandom), 8'($urandom));
                    lvl = 0;
                    sent++;
                end
            end else begin
                send_item(MODE_TILING, 5'($urandom_range(0, 31)), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = CFG_ACTION_COUNT;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: bias, tier skip, rejection on tier order, tier code and dims, empty finish
        send_item(MODE_TILING, 5'd0, 8'd255);
        send_item(MODE_TILING, 5'd1, 8'd0);
        send_item(MODE_TILING, 5'd16, 8'd2);
        send_item(MODE_TILING, 5'd3, 8'd1);
        send_item(MODE_TILING, 5'd2, 8'd3);
        send_item(MODE_TILING, 5'd5, 8'd255);
        send_item(MODE_TILING, 5'd17, 8'd2);
        send_item(MODE_TILING, 5'd31, 8'd2);
        send_item(MODE_TILING, 5'd0, 8'd0);
        send_item(MODE_FINISH, 5'd0, 8'd0);
        send_item(MODE_FINISH, 5'd31, 8'd255);

        // All registers at their maximum: products wrap at 32 bits
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_TILING, 5'd16, 8'd1);
        send_item(MODE_TILING, 5'd0, 8'd7);
        send_item(MODE_TILING, 5'd1, 8'd2);
        send_item(MODE_FINISH, 5'd0, 8'd0);

        // Zero tilings per set gives a zero per-tiling size
        set_config(16'd5, 16'd0, 16'd3);
        send_item(MODE_TILING, 5'd2, 8'd0);
        send_item(MODE_TILING, 5'd0, 8'd0);
        send_item(MODE_FINISH, 5'd0, 8'd0);

        // Random phases, each with its own settings and idle profile
        for (int p = 0; p < 8; p++) begin
            set_config(pick_reg(), pick_reg(), pick_reg());
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 58;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 58;
                end
                default: begin
                    tx_idle_pct  = 20;
                    rx_stall_pct = 20;
                end
            endcase
            run_layouts(235);
        end

        settle();
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Timeout
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
